// ===== rtl/rgb_3x3_sharpen_convolution_defines.svh =====
// Assertion macros for the sharpen filter RTL.
`ifndef RGB_3X3_SHARPEN_CONVOLUTION_DEFINES_SVH
`define RGB_3X3_SHARPEN_CONVOLUTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGBSH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RGBSH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rgbsh_pkg.sv =====
// Types and constants of the RGB 3x3 sharpen filter.
package rgbsh_pkg;

	localparam int PIX_W          = 24;
	localparam int CH_W           = 8;
	localparam int NUM_CH         = 3;
	localparam int CH_MAX         = 255;
	localparam int KERNEL_CENTER  = 10;

	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 12;
	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	// APB register map: register i at byte address 4*i
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Result slots released by one pixel, in output order
	localparam int NUM_SLOTS       = 4;
	localparam int SLOT_ABOVE_LEFT = 0;
	localparam int SLOT_ABOVE      = 1;
	localparam int SLOT_LEFT       = 2;
	localparam int SLOT_SELF       = 3;

	typedef logic [PIX_W-1:0] pixel_t;

	// win[row][col]: row 0 is two rows up, col 0 is two columns left
	typedef logic [2:0][2:0][PIX_W-1:0] window_t;

	// Offset of the 3x3 tap frame inside the zero-padded 4x4 window
	typedef struct packed {
		logic row_ofs;
		logic col_ofs;
	} tap_sel_t;

	typedef struct packed {
		logic row_ge1;
		logic row_ge2;
		logic col_zero;
		logic last_col;
		logic last_row;
	} pix_flags_t;

endpackage

// ===== rtl/rgbsh_kernel.sv =====
// Sharpen kernel on one 3x3 tap frame of the window, all three channels.
module rgbsh_kernel (
	input  rgbsh_pkg::window_t  win,
	input  rgbsh_pkg::tap_sel_t sel,
	output rgbsh_pkg::pixel_t   pix
);
	import rgbsh_pkg::*;

	localparam int SUM_W       = 12;
	localparam int DIFF_W      = SUM_W + 1;
	localparam int CENTER_GAIN = KERNEL_CENTER + 1;

	logic [3:0][3:0][PIX_W-1:0] ext;
	logic [2:0][2:0][PIX_W-1:0] tap;

	// Window padded with a zero row below and a zero column right
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				ext[i][j] = '0;
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				ext[i][j] = win[i][j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (sel.row_ofs) begin
					tap[i][j] = sel.col_ofs ? ext[i+1][j+1] : ext[i+1][j];
				end else begin
					tap[i][j] = sel.col_ofs ? ext[i][j+1] : ext[i][j];
				end
			end
		end
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
		logic [2:0][SUM_W-1:0]    row_sum;
		logic [SUM_W-1:0]         total;
		logic [SUM_W-1:0]         ctr_gain;
		logic signed [DIFF_W-1:0] diff;
		logic [DIFF_W-3:0]        half;

		// 10*center - neighbors == 11*center - sum of all nine taps
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				row_sum[i] = SUM_W'(tap[i][0][ch*CH_W +: CH_W])
					+ SUM_W'(tap[i][1][ch*CH_W +: CH_W])
					+ SUM_W'(tap[i][2][ch*CH_W +: CH_W]);
			end
			total    = row_sum[0] + row_sum[1] + row_sum[2];
			ctr_gain = SUM_W'(tap[1][1][ch*CH_W +: CH_W]) * SUM_W'(CENTER_GAIN);
			diff     = $signed({1'b0, ctr_gain}) - $signed({1'b0, total});
			half     = diff[DIFF_W-2:1];
			// negative sums truncate toward zero and clamp to zero alike
			if (diff[DIFF_W-1] || (diff == '0)) begin
				pix[ch*CH_W +: CH_W] = '0;
			end else if (half > (DIFF_W-2)'(CH_MAX)) begin
				pix[ch*CH_W +: CH_W] = CH_W'(CH_MAX);
			end else begin
				pix[ch*CH_W +: CH_W] = half[CH_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/rgb_3x3_sharpen_convolution.sv =====
// RGB 3x3 sharpen filter over a raster pixel stream with an APB register port.
//
// Pixels enter in raster order, one beat per clock while in_ready is high, for
// a frame of frame_width x frame_height (APB 0x0 and 0x4; zero acts as one,
// values above MAX_WIDTH / MAX_HEIGHT act as the maximum). Each channel is
// filtered with the kernel {-1 -1 -1; -1 10 -1; -1 -1 -1}, halved toward zero
// and clamped to 0..255; pixels outside the frame count as zero. An input beat
// releases up to four output beats: normally the pixel one row up and one
// column left, plus extra ones on the last column and the last row. The block
// takes one pixel per clock while each pixel releases at most one result and
// the output is not stalled; a pixel that releases several results holds
// stage 2 until each has entered the output register, which is what sets the
// rate on the last column and the last row. Both rows above the current pixel
// sit in one line memory of MAX_WIDTH x 48 bits with a registered read, read at
// input and written back when the pixel leaves stage 1; the previous write is
// forwarded when it hits the same column. The line memory has no clearing
// pass; the block accepts pixels right after reset.
`include "rgb_3x3_sharpen_convolution_defines.svh"

module rgb_3x3_sharpen_convolution #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4095
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rgbsh_pkg::ADDR_W-1:0]     paddr,
	input  logic [rgbsh_pkg::DATA_W-1:0]     pwdata,
	output logic [rgbsh_pkg::DATA_W-1:0]     prdata,
	output logic                             pready,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rgbsh_pkg::CH_W-1:0]       in_red,
	input  logic [rgbsh_pkg::CH_W-1:0]       in_green,
	input  logic [rgbsh_pkg::CH_W-1:0]       in_blue,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rgbsh_pkg::CH_W-1:0]       out_red,
	output logic [rgbsh_pkg::CH_W-1:0]       out_green,
	output logic [rgbsh_pkg::CH_W-1:0]       out_blue,
	output logic                             last_in_run,
	output logic                             end_of_frame
);
	import rgbsh_pkg::*;

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT + 1);
	localparam int WCMP = (AW + 1 > FRAME_WIDTH_W) ? AW + 1 : FRAME_WIDTH_W;
	localparam int HCMP = (RW + 1 > FRAME_HEIGHT_W) ? RW + 1 : FRAME_HEIGHT_W;
	localparam int LW   = 2 * PIX_W;

	// ---------------- configuration ----------------
	logic [FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [FRAME_HEIGHT_W-1:0] frame_height_q;
	logic [REG_IDX_W-1:0]      cfg_idx;
	logic                      cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FRAME_WIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FRAME_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------- raster position ----------------
	logic [AW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [WCMP-1:0] fw_ext;
	logic [WCMP-1:0] w_eff;
	logic [HCMP-1:0] fh_ext;
	logic [HCMP-1:0] h_eff;
	pix_flags_t      flags_in;
	logic            in_acc;

	always_comb begin
		fw_ext = WCMP'(frame_width_q);
		if (fw_ext == '0) begin
			w_eff = WCMP'(1);
		end else if (fw_ext > WCMP'(MAX_WIDTH)) begin
			w_eff = WCMP'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		fh_ext = HCMP'(frame_height_q);
		if (fh_ext == '0) begin
			h_eff = HCMP'(1);
		end else if (fh_ext > HCMP'(MAX_HEIGHT)) begin
			h_eff = HCMP'(MAX_HEIGHT);
		end else begin
			h_eff = fh_ext;
		end
		flags_in.row_ge1  = (row_q != '0);
		flags_in.row_ge2  = (HCMP'(row_q) >= HCMP'(2));
		flags_in.col_zero = (col_q == '0);
		flags_in.last_col = (WCMP'(col_q) + WCMP'(1)) >= w_eff;
		flags_in.last_row = (HCMP'(row_q) + HCMP'(1)) >= h_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (flags_in.last_col) begin
				col_q <= '0;
				row_q <= flags_in.last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// ---------------- stage 1: line memory read-modify-write ----------------
	logic                  s1_valid;
	logic                  s1_adv;
	pixel_t                px_s1;
	logic [AW-1:0]         col_s1;
	pix_flags_t            flags_s1;
	logic                  fwd_s1;
	logic [LW-1:0]         fwd_data_s1;
	logic [LW-1:0]         rd_s1;
	logic [LW-1:0]         line_mem [MAX_WIDTH];
	logic [LW-1:0]         rd_eff;
	logic [LW-1:0]         wr_data;
	pixel_t                up;
	pixel_t                up2;
	logic                  s2_free;

	assign in_ready = !s1_valid || s1_adv;
	assign in_acc   = in_valid && in_ready;
	assign s1_adv   = s1_valid && s2_free;

	// entry layout: {row above, row two above}
	assign rd_eff  = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign up      = flags_s1.row_ge1 ? rd_eff[LW-1:PIX_W] : '0;
	assign up2     = flags_s1.row_ge2 ? rd_eff[PIX_W-1:0] : '0;
	assign wr_data = {px_s1, up};

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			line_mem[col_s1] <= wr_data;
		end
		if (in_acc) begin
			rd_s1 <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (in_acc) begin
			s1_valid <= 1'b1;
			// write-back lands on the edge of this read: take it directly
			fwd_s1   <= s1_adv && (col_s1 == col_q);
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
			fwd_s1   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1       <= {in_red, in_green, in_blue};
			col_s1      <= col_q;
			flags_s1    <= flags_in;
			fwd_data_s1 <= wr_data;
		end
	end

	// ---------------- window ----------------
	window_t window_q;
	window_t win_nx;

	always_comb begin
		win_nx = window_q;
		for (int i = 0; i < 3; i++) begin
			if (flags_s1.col_zero) begin
				win_nx[i][0] = '0;
				win_nx[i][1] = '0;
			end else begin
				win_nx[i][0] = window_q[i][1];
				win_nx[i][1] = window_q[i][2];
			end
		end
		win_nx[0][2] = up2;
		win_nx[1][2] = up;
		win_nx[2][2] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (s1_adv) begin
			window_q <= win_nx;
		end
	end

	// ---------------- stage 2: result slots of the windowed pixel ----------------
	logic [NUM_SLOTS-1:0] pend_q;
	logic [NUM_SLOTS-1:0] pend_new;
	logic [NUM_SLOTS-1:0] pend_first;
	logic [NUM_SLOTS-1:0] pend_rest;
	logic                 emit;
	tap_sel_t             sel;
	pixel_t               kern_pix;

	logic                 out_valid_q;
	pixel_t               out_pix_q;
	logic                 last_q;
	logic                 eof_q;

	always_comb begin
		pend_new                  = '0;
		pend_new[SLOT_ABOVE_LEFT] = flags_s1.row_ge1 && !flags_s1.col_zero;
		pend_new[SLOT_ABOVE]      = flags_s1.row_ge1 && flags_s1.last_col;
		pend_new[SLOT_LEFT]       = flags_s1.last_row && !flags_s1.col_zero;
		pend_new[SLOT_SELF]       = flags_s1.last_row && flags_s1.last_col;
	end

	assign pend_first  = pend_q & (~pend_q + NUM_SLOTS'(1));
	assign pend_rest   = pend_q & ~pend_first;
	assign emit        = (pend_q != '0) && (!out_valid_q || out_ready);
	assign s2_free     = (pend_q == '0) || (emit && (pend_rest == '0));
	assign sel.row_ofs = pend_first[SLOT_LEFT] || pend_first[SLOT_SELF];
	assign sel.col_ofs = pend_first[SLOT_ABOVE] || pend_first[SLOT_SELF];

	rgbsh_kernel u_kernel (
		.win (window_q),
		.sel (sel),
		.pix (kern_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (s1_adv) begin
			pend_q <= pend_new;
		end else if (emit) begin
			pend_q <= pend_rest;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pix_q <= kern_pix;
			last_q    <= (pend_rest == '0);
			eof_q     <= pend_first[SLOT_SELF];
		end
	end

	assign out_valid    = out_valid_q;
	assign out_red      = out_pix_q[3*CH_W-1:2*CH_W];
	assign out_green    = out_pix_q[2*CH_W-1:CH_W];
	assign out_blue     = out_pix_q[CH_W-1:0];
	assign last_in_run  = last_q;
	assign end_of_frame = eof_q;

	// ---------------- assertions ----------------
	`RGBSH_ASSERT_IMP(a_adv_one_slot, clk, arst_n, s1_adv, $countones(pend_q) <= 1, "window advanced with results pending")
	`RGBSH_ASSERT_IMP(a_fwd_valid, clk, arst_n, fwd_s1, s1_valid, "forward flag without a pixel in stage 1")
	`RGBSH_ASSERT_IMP(a_eof_last, clk, arst_n, out_valid_q && eof_q, last_q, "end of frame beat not last of its run")
	`RGBSH_ASSERT_NXT(a_s1_drain, clk, arst_n, s1_adv && !in_acc, !s1_valid, "stage 1 kept a pixel it passed on")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the RGB 3x3 sharpen filter: directed table and random frames.
`timescale 1ns / 1ps

module tb_top;
	import rgbsh_pkg::*;

	localparam int FRAME_MAX_W = 1024;
	localparam int FRAME_MAX_H = 4095;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 400;
	localparam int RAND_ITEMS = 200;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last_in_run;
		logic            end_of_frame;
	} sharp_res_t;

	localparam sharp_res_t NO_RES        = '0;
	localparam sharp_res_t RES_SMALL_EOF = '{8'd5, 8'd10, 8'd15, 1'b1, 1'b1};
	localparam sharp_res_t RES_WHITE_EOF = '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1};
	localparam sharp_res_t RES_BLACK_EOF = '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1};

	typedef enum logic [1:0] {ROW_PIX, ROW_SET_W, ROW_SET_H} dir_kind_t;

	// typed rows carry their results; the rest go through the predictor
	typedef struct packed {
		dir_kind_t        kind;
		logic [31:0]      arg;
		logic             typed;
		logic [2:0]       n_typed;
		sharp_res_t [0:3] fixed;
	} dir_row_t;

	dir_row_t dir_rows [0:35] = '{
		'{ROW_SET_W, 32'd1, 1'b0, 3'd0, '0},
		'{ROW_SET_H, 32'd1, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h010203, 1'b1, 3'd1, '{RES_SMALL_EOF, NO_RES, NO_RES, NO_RES}},
		'{ROW_PIX, 32'hFFFFFF, 1'b1, 3'd1, '{RES_WHITE_EOF, NO_RES, NO_RES, NO_RES}},
		'{ROW_PIX, 32'h000000, 1'b1, 3'd1, '{RES_BLACK_EOF, NO_RES, NO_RES, NO_RES}},
		'{ROW_PIX, 32'hAA55F0, 1'b0, 3'd0, '0},
		// 2x1: dark then white pixel, negative clamp then positive clamp
		'{ROW_SET_W, 32'd2, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h000000, 1'b1, 3'd0, '0},
		'{ROW_PIX, 32'hFFFFFF, 1'b1, 3'd2, '{NO_RES, RES_WHITE_EOF, NO_RES, NO_RES}},
		// zero sizes act as one
		'{ROW_SET_W, 32'd0, 1'b0, 3'd0, '0},
		'{ROW_SET_H, 32'd0, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h010203, 1'b1, 3'd1, '{RES_SMALL_EOF, NO_RES, NO_RES, NO_RES}},
		'{ROW_PIX, 32'h0F7E81, 1'b0, 3'd0, '0},
		// oversized width, then shrunk past the current column mid-row
		'{ROW_SET_W, 32'd2047, 1'b0, 3'd0, '0},
		'{ROW_SET_H, 32'd2, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h102030, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h3C5A96, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h80FF01, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h7F007F, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h445566, 1'b0, 3'd0, '0},
		'{ROW_SET_W, 32'd3, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'hE1D2C3, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h0A0B0C, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'hF0F0F0, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h55AA33, 1'b0, 3'd0, '0},
		// height shrunk below the current row mid-frame
		'{ROW_SET_W, 32'd2, 1'b0, 3'd0, '0},
		'{ROW_SET_H, 32'd5, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h202020, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'hFF0000, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h00FF00, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h0000FF, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h808080, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h7F7F7F, 1'b0, 3'd0, '0},
		'{ROW_SET_H, 32'd2, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'h010101, 1'b0, 3'd0, '0},
		'{ROW_PIX, 32'hFEFEFE, 1'b0, 3'd0, '0}
	};

	logic clk;
	logic arst_n = 1'b0;

	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [ADDR_W-1:0]   paddr   = '0;
	logic [DATA_W-1:0]   pwdata  = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [CH_W-1:0]     in_red    = '0;
	logic [CH_W-1:0]     in_green  = '0;
	logic [CH_W-1:0]     in_blue   = '0;

	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CH_W-1:0]     out_red;
	logic [CH_W-1:0]     out_green;
	logic [CH_W-1:0]     out_blue;
	logic                last_in_run;
	logic                end_of_frame;

	// shadow copy of the filter state
	logic [FRAME_WIDTH_W-1:0]  cfg_width  = FRAME_WIDTH_RST;
	logic [FRAME_HEIGHT_W-1:0] cfg_height = FRAME_HEIGHT_RST;
	pixel_t                    row_up_copy  [FRAME_MAX_W];
	pixel_t                    row_up2_copy [FRAME_MAX_W];
	pixel_t                    shadow_win   [3][3];
	logic [9:0]                col_pos = '0;
	logic [11:0]               row_pos = '0;

	sharp_res_t expected_px_q [$];
	int         mismatch_cnt = 0;
	int         beats_seen = 0;
	bit         long_hold_req = 1'b0;

	rgb_3x3_sharpen_convolution #(
		.MAX_WIDTH  (FRAME_MAX_W),
		.MAX_HEIGHT (FRAME_MAX_H)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_red       (in_red),
		.in_green     (in_green),
		.in_blue      (in_blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.last_in_run  (last_in_run),
		.end_of_frame (end_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int eff_size(int v, int top);
		return (v < 1) ? 1 : (v > top) ? top : v;
	endfunction

	// mostly zero, some short, a few long
	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 70)
			return 0;
		if (k < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void flag_mismatch(string msg);
		if (mismatch_cnt < 10)
			$display("%s", msg);
		mismatch_cnt++;
	endfunction

	// kernel over the 3x3 taps starting at (rb, cb) of the window; outside taps are zero
	function automatic sharp_res_t sharpen_tap(int rb, int cb, bit eof);
		sharp_res_t res;
		logic [CH_W-1:0] chv [3];
		int sum;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					if (rb + i <= 2 && cb + j <= 2)
						sum += int'(shadow_win[rb + i][cb + j][8 * (2 - ch) +: 8])
							* ((i == 1 && j == 1) ? KERNEL_CENTER : -1);
			sum = sum / 2;
			chv[ch] = (sum < 0) ? 8'd0 : (sum > CH_MAX) ? 8'(CH_MAX) : 8'(sum);
		end
		res = '{chv[0], chv[1], chv[2], 1'b0, eof};
		return res;
	endfunction

	task automatic sharpen_predict(input pixel_t px, input bit keep);
		int ew, eh, c, r, n;
		pixel_t up, up2;
		bit lc, lr;
		sharp_res_t res [4];
		ew = eff_size(cfg_width, FRAME_MAX_W);
		eh = eff_size(cfg_height, FRAME_MAX_H);
		c = col_pos;
		r = row_pos;
		up  = (r >= 1) ? row_up_copy[c]  : '0;
		up2 = (r >= 2) ? row_up2_copy[c] : '0;
		for (int i = 0; i < 3; i++) begin
			shadow_win[i][0] = (c == 0) ? '0 : shadow_win[i][1];
			shadow_win[i][1] = (c == 0) ? '0 : shadow_win[i][2];
		end
		shadow_win[0][2] = up2;
		shadow_win[1][2] = up;
		shadow_win[2][2] = px;
		row_up2_copy[c] = up;
		row_up_copy[c]  = px;
		lc = (c + 1 >= ew);
		lr = (r + 1 >= eh);
		n = 0;
		if (r >= 1 && c >= 1) begin
			res[n] = sharpen_tap(0, 0, 1'b0);
			n++;
		end
		if (r >= 1 && lc) begin
			res[n] = sharpen_tap(0, 1, 1'b0);
			n++;
		end
		if (lr && c >= 1) begin
			res[n] = sharpen_tap(1, 0, 1'b0);
			n++;
		end
		if (lr && lc) begin
			res[n] = sharpen_tap(1, 1, 1'b1);
			n++;
		end
		if (n > 0)
			res[n - 1].last_in_run = 1'b1;
		if (lc) begin
			col_pos = '0;
			row_pos = lr ? '0 : 12'(r + 1);
		end else begin
			col_pos = 10'(c + 1);
		end
		if (keep)
			for (int k = 0; k < n; k++)
				expected_px_q.push_back(res[k]);
	endtask

	task automatic check_beat();
		sharp_res_t got, want;
		got = '{out_red, out_green, out_blue, last_in_run, end_of_frame};
		beats_seen++;
		if (expected_px_q.size() == 0) begin
			flag_mismatch($sformatf("beat %0d: none expected, got %p", beats_seen, got));
			return;
		end
		want = expected_px_q.pop_front();
		if (got !== want)
			flag_mismatch($sformatf("beat %0d: expected %p, got %p", beats_seen, want, got));
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		logic [31:0] mask;
		mask = (idx == REG_FRAME_WIDTH) ? (32'd1 << FRAME_WIDTH_W) - 1
			: (32'd1 << FRAME_HEIGHT_W) - 1;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_FRAME_WIDTH)
			cfg_width = val[FRAME_WIDTH_W-1:0];
		else
			cfg_height = val[FRAME_HEIGHT_W-1:0];
		// read back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== (val & mask))
			flag_mismatch($sformatf("reg %0d: wrote %0h, read %0h", idx, val, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// returns at the edge that accepts the beat
	task automatic send_px(input pixel_t px);
		in_valid <= 1'b1;
		in_red   <= px[23:16];
		in_green <= px[15:8];
		in_blue  <= px[7:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic idle_in(input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// block is idle once all results are out and pixels that release none have settled
	task automatic wait_drained();
		idle_in(1);
		while (expected_px_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic stream_frame(input int w_reg, input int h_reg, input int mode,
		input bit no_gaps);
		int npx;
		pixel_t base, px;
		wait_drained();
		apb_write(REG_FRAME_WIDTH, w_reg);
		apb_write(REG_FRAME_HEIGHT, h_reg);
		npx = eff_size(w_reg & 'h7FF, FRAME_MAX_W) * eff_size(h_reg & 'hFFF, FRAME_MAX_H);
		base = pixel_t'($urandom());
		for (int i = 0; i < npx; i++) begin
			case (mode)
				1: px = {$urandom_range(0, 1) ? 8'hFF : 8'h00,
					$urandom_range(0, 1) ? 8'hFF : 8'h00,
					$urandom_range(0, 1) ? 8'hFF : 8'h00};
				// near-flat area: small offsets around a random base
				2: px = {base[23:16] + 8'($urandom_range(0, 15)),
					base[15:8] + 8'($urandom_range(0, 15)),
					base[7:0] + 8'($urandom_range(0, 15))};
				default: px = pixel_t'($urandom());
			endcase
			send_px(px);
			sharpen_predict(px, 1'b1);
			idle_in(no_gaps ? 0 : gap_len());
		end
	endtask

	initial begin : pixel_source
		int rand_items, w_reg, h_reg;
		pixel_t px;
		foreach (shadow_win[i, j])
			shadow_win[i][j] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_SET_W: begin
					wait_drained();
					apb_write(REG_FRAME_WIDTH, dir_rows[i].arg);
				end
				ROW_SET_H: begin
					wait_drained();
					apb_write(REG_FRAME_HEIGHT, dir_rows[i].arg);
				end
				default: begin
					px = dir_rows[i].arg[23:0];
					send_px(px);
					sharpen_predict(px, !dir_rows[i].typed);
					if (dir_rows[i].typed)
						for (int k = 0; k < dir_rows[i].n_typed; k++)
							expected_px_q.push_back(dir_rows[i].fixed[k]);
					idle_in(gap_len());
				end
			endcase
		end

		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			case ($urandom_range(0, 19))
				0:       w_reg = 0;
				15, 16, 17, 18, 19: w_reg = $urandom_range(9, 24);
				default: w_reg = $urandom_range(1, 8);
			endcase
			h_reg = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
			rand_items += eff_size(w_reg, FRAME_MAX_W) * eff_size(h_reg, FRAME_MAX_H);
			stream_frame(w_reg, h_reg, $urandom_range(0, 3), $urandom_range(0, 3) == 0);
		end

		// long output stall while the input keeps offering pixels
		long_hold_req = 1'b1;
		stream_frame(8, 4, 0, 1'b1);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : result_sink
		int stall_left, phase_left;
		bit calm;
		stall_left = 0;
		phase_left = 0;
		calm = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_beat();
			if (phase_left == 0) begin
				calm = ($urandom_range(0, 2) == 0);
				phase_left = $urandom_range(20, 200);
			end else begin
				phase_left--;
			end
			if (long_hold_req && out_valid) begin
				// hold off long enough for the input side to back up
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!calm)
					stall_left = gap_len();
			end
		end
	end

endmodule
